[rtl/mrrp_pkg.sv]
package mrrp_pkg;

  typedef enum logic [1:0] {
    PH_HUNT,
    PH_HEAD,
    PH_DATA,
    PH_CRC
  } phase_t;

  localparam logic [7:0]  FC_READ_COILS  = 8'd1;
  localparam logic [7:0]  FC_READ_REGS   = 8'd3;
  localparam logic [7:0]  FC_WRITE_COIL  = 8'd5;
  localparam logic [7:0]  FC_WRITE_REG   = 8'd6;
  localparam logic [7:0]  FC_WRITE_MULTI = 8'd16;
  localparam logic [7:0]  FUNC_MASK      = 8'h7F;
  localparam int          EXC_BIT        = 7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  localparam logic [2:0]  ST_OK          = 3'd0;
  localparam logic [2:0]  ST_EXC_OK      = 3'd1;
  localparam logic [2:0]  ST_CRC_BAD     = 3'd2;
  localparam logic [2:0]  ST_EXC_CRC_BAD = 3'd3;
  localparam logic [2:0]  ST_COUNT_BIG   = 3'd4;

  localparam logic        KIND_DATA   = 1'b0;
  localparam logic        KIND_REPORT = 1'b1;

  localparam logic        CFG_DEV_ADDRESS = 1'b0;
  localparam logic        CFG_MAX_FRAME   = 1'b1;

  localparam logic [8:0]  DEV_ADDRESS_RST = 9'd1;
  localparam logic [8:0]  MAX_FRAME_RST   = 9'd256;
  localparam logic [9:0]  FRAME_OVERHEAD  = 10'd5;
  localparam logic [7:0]  HEAD_LEN_SHORT  = 8'd1;
  localparam logic [7:0]  HEAD_LEN_WRITE  = 8'd4;
  localparam logic [7:0]  CRC_LEN         = 8'd2;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       restart;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic [7:0]  func_code;
    logic [15:0] write_addr;
    logic [15:0] reg_value;
    logic [7:0]  byte_count;
    logic [7:0]  exception_code;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
  } out_item_t;

  function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic logic is_known_func(input logic [7:0] code);
    logic [7:0] base;
    base = code & FUNC_MASK;
    return (base == FC_READ_COILS) || (base == FC_READ_REGS) || (base == FC_WRITE_COIL) ||
           (base == FC_WRITE_REG) || (base == FC_WRITE_MULTI);
  endfunction

endpackage

[rtl/modbus_rtu_response_parser.sv]
// Requests wait in the input register, results in the result register.
// Throughput: one request per cycle; the input register and the result
// register each hold one item, and a held result stalls the core while the
// input register takes one more request before in_ready drops.
// Reset (rst_n low at a clock edge): hunting with no byte held, no result
// pending, device address 1, max_frame_bytes = 256.
module modbus_rtu_response_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [2:0]  out_status,
  output logic [7:0]  out_func_code,
  output logic [15:0] out_write_addr,
  output logic [15:0] out_reg_value,
  output logic [7:0]  out_byte_count,
  output logic [7:0]  out_exception_code,
  output logic [7:0]  out_data_byte,
  output logic [7:0]  out_data_index
);
  import mrrp_pkg::*;

  in_item_t  in_item;
  in_item_t  s_item;
  logic      s_valid;
  logic      take;
  out_item_t out_item;

  assign in_item.rx_byte = in_rx_byte;
  assign in_item.restart = in_restart;

  mrrp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (take),
    .s_valid  (s_valid),
    .s_item   (s_item)
  );

  mrrp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .s_valid   (s_valid),
    .s_item    (s_item),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  assign out_kind           = out_item.kind;
  assign out_status         = out_item.status;
  assign out_func_code      = out_item.func_code;
  assign out_write_addr     = out_item.write_addr;
  assign out_reg_value      = out_item.reg_value;
  assign out_byte_count     = out_item.byte_count;
  assign out_exception_code = out_item.exception_code;
  assign out_data_byte      = out_item.data_byte;
  assign out_data_index     = out_item.data_index;

endmodule

[rtl/mrrp_in_stage.sv]
module mrrp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrrp_pkg::in_item_t in_item,
  input  logic              take,
  output logic              s_valid,
  output mrrp_pkg::in_item_t s_item
);
  import mrrp_pkg::*;

  logic     s_valid_r;
  in_item_t s_item_r;

  assign in_ready = !s_valid_r || take;
  assign s_valid  = s_valid_r;
  assign s_item   = s_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid_r <= 1'b1;
    end else if (take) begin
      s_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_item;
    end
  end

endmodule

[rtl/mrrp_core.sv]
module mrrp_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_wr_en,
  input  logic               cfg_index,
  input  logic [8:0]         cfg_wdata,
  input  logic               s_valid,
  input  mrrp_pkg::in_item_t s_item,
  output logic               take,
  output logic               out_valid,
  input  logic               out_ready,
  output mrrp_pkg::out_item_t out_item
);
  import mrrp_pkg::*;

  logic [7:0]  slave_id_r;
  logic [8:0]  max_frame_r;

  phase_t      phase_r, phase_nxt;
  logic [7:0]  prev_byte_r, prev_byte_nxt;
  logic        have_prev_r, have_prev_nxt;
  logic [7:0]  frame_func_r, frame_func_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic [7:0]  payload_pos_r, payload_pos_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] held_addr_r, held_addr_nxt;
  logic [15:0] held_value_r, held_value_nxt;
  logic [7:0]  held_count_r, held_count_nxt;
  logic [7:0]  held_exc_r, held_exc_nxt;

  logic        out_valid_r;
  out_item_t   out_item_r;

  logic        fire;
  logic        emit;
  out_item_t   res;
  logic [7:0]  b;
  logic [15:0] crc_byte;
  logic [7:0]  left_dec;
  logic [9:0]  need_bytes;
  logic        is_exc;

  assign take      = !out_valid_r || out_ready;
  assign fire      = s_valid && take;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign b          = s_item.rx_byte;
  assign crc_byte   = crc16_update(crc_r, b);
  assign left_dec   = bytes_left_r - {7'd0, (bytes_left_r != 8'd0)};
  assign need_bytes = {2'b00, b} + FRAME_OVERHEAD;
  assign is_exc     = frame_func_r[EXC_BIT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_id_r  <= DEV_ADDRESS_RST[7:0];
      max_frame_r <= MAX_FRAME_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_DEV_ADDRESS: slave_id_r  <= cfg_wdata[7:0];
        CFG_MAX_FRAME:   max_frame_r <= cfg_wdata;
        default:         max_frame_r <= max_frame_r;
      endcase
    end
  end

  always_comb begin
    phase_nxt       = phase_r;
    prev_byte_nxt   = prev_byte_r;
    have_prev_nxt   = have_prev_r;
    frame_func_nxt  = frame_func_r;
    bytes_left_nxt  = bytes_left_r;
    payload_pos_nxt = payload_pos_r;
    crc_nxt         = crc_r;
    held_addr_nxt   = held_addr_r;
    held_value_nxt  = held_value_r;
    held_count_nxt  = held_count_r;
    held_exc_nxt    = held_exc_r;
    emit            = 1'b0;
    res             = '0;
    res.kind           = KIND_REPORT;
    res.func_code      = frame_func_r;
    res.write_addr     = held_addr_r;
    res.reg_value      = held_value_r;
    res.byte_count     = held_count_r;
    res.exception_code = held_exc_r;

    if (s_item.restart) begin
      phase_nxt     = PH_HUNT;
      have_prev_nxt = 1'b0;
    end else begin
      case (phase_r)
        PH_HEAD: begin
          crc_nxt = crc_byte;
          if (is_exc) begin
            held_exc_nxt   = b;
            bytes_left_nxt = CRC_LEN;
            phase_nxt      = PH_CRC;
          end else if (frame_func_r == FC_READ_COILS || frame_func_r == FC_READ_REGS) begin
            held_count_nxt = b;
            if (need_bytes > {1'b0, max_frame_r}) begin
              emit           = 1'b1;
              res.status     = ST_COUNT_BIG;
              res.byte_count = b;
              phase_nxt      = PH_HUNT;
              have_prev_nxt  = 1'b0;
            end else begin
              payload_pos_nxt = 8'd0;
              if (b == 8'd0) begin
                bytes_left_nxt = CRC_LEN;
                phase_nxt      = PH_CRC;
              end else begin
                bytes_left_nxt = b;
                phase_nxt      = PH_DATA;
              end
            end
          end else begin
            held_addr_nxt  = {held_addr_r[7:0], held_value_r[15:8]};
            held_value_nxt = {held_value_r[7:0], b};
            if (left_dec == 8'd0) begin
              bytes_left_nxt = CRC_LEN;
              phase_nxt      = PH_CRC;
            end else begin
              bytes_left_nxt = left_dec;
            end
          end
        end
        PH_DATA: begin
          crc_nxt            = crc_byte;
          emit               = 1'b1;
          res                = '0;
          res.kind           = KIND_DATA;
          res.status         = ST_OK;
          res.func_code      = frame_func_r;
          res.byte_count     = held_count_r;
          res.data_byte      = b;
          res.data_index     = payload_pos_r;
          payload_pos_nxt    = payload_pos_r + 8'd1;
          if (left_dec == 8'd0) begin
            bytes_left_nxt = CRC_LEN;
            phase_nxt      = PH_CRC;
          end else begin
            bytes_left_nxt = left_dec;
          end
        end
        PH_CRC: begin
          crc_nxt        = crc_byte;
          bytes_left_nxt = left_dec;
          if (left_dec == 8'd0) begin
            emit          = 1'b1;
            if (crc_byte == 16'd0) begin
              res.status = is_exc ? ST_EXC_OK : ST_OK;
            end else begin
              res.status = is_exc ? ST_EXC_CRC_BAD : ST_CRC_BAD;
            end
            phase_nxt     = PH_HUNT;
            have_prev_nxt = 1'b0;
          end
        end
        default: begin
          phase_nxt = PH_HUNT;
          if (have_prev_r && prev_byte_r == slave_id_r && is_known_func(b)) begin
            frame_func_nxt  = b;
            crc_nxt         = crc_byte;
            held_addr_nxt   = 16'd0;
            held_value_nxt  = 16'd0;
            held_count_nxt  = 8'd0;
            held_exc_nxt    = 8'd0;
            payload_pos_nxt = 8'd0;
            if (b[EXC_BIT] || b == FC_READ_COILS || b == FC_READ_REGS) begin
              bytes_left_nxt = HEAD_LEN_SHORT;
            end else begin
              bytes_left_nxt = HEAD_LEN_WRITE;
            end
            phase_nxt     = PH_HEAD;
            have_prev_nxt = 1'b0;
          end else begin
            prev_byte_nxt = b;
            crc_nxt       = crc16_update(CRC_INIT, b);
            have_prev_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      have_prev_r <= 1'b0;
    end else if (fire) begin
      phase_r     <= phase_nxt;
      have_prev_r <= have_prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      prev_byte_r   <= prev_byte_nxt;
      frame_func_r  <= frame_func_nxt;
      bytes_left_r  <= bytes_left_nxt;
      payload_pos_r <= payload_pos_nxt;
      crc_r         <= crc_nxt;
      held_addr_r   <= held_addr_nxt;
      held_value_r  <= held_value_nxt;
      held_count_r  <= held_count_nxt;
      held_exc_r    <= held_exc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (take && fire && emit) begin
      out_item_r <= res;
    end
  end

endmodule

[rtl/mrrp_checker.sv]
module mrrp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_restart,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [2:0]  out_status,
  input logic [7:0]  out_func_code,
  input logic [7:0]  out_byte_count,
  input logic [7:0]  out_data_byte,
  input logic [7:0]  out_data_index
);
  import mrrp_pkg::*;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result pending right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte) && $stable(out_status)
      && $stable(out_func_code))
    else $error("stalled result changed");

  a_restart_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_restart ##1 (!out_valid || out_ready) |=> !out_valid)
    else $error("restart request produced a result");

  a_data_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_DATA |-> out_data_index < out_byte_count && out_status == ST_OK)
    else $error("data byte outside read count");

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input blocked while result side drains");

endmodule

bind modbus_rtu_response_parser mrrp_checker u_checker (.*);
